/* sv/ifp_pkg.sv */
// Package for the infix to postfix converter: characters, stack depth and precedence.
`default_nettype none

package ifp_pkg;

    // Default operator stack depth
    localparam int STACK_DEPTH_DEF = 32;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Precedence ranks, shifted up by one so that they stay unsigned
    localparam logic [1:0] RANK_OTHER = 2'd0;
    localparam logic [1:0] RANK_ADD   = 2'd1;
    localparam logic [1:0] RANK_MUL   = 2'd2;

    // Input item kinds
    localparam logic MODE_CHAR  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    function automatic logic [1:0] f_rank(input logic [7:0] c);
        logic [1:0] r;
        r = RANK_OTHER;
        if (c == CH_PLUS || c == CH_MINUS) begin
            r = RANK_ADD;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            r = RANK_MUL;
        end
        return r;
    endfunction

    function automatic logic f_is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

`default_nettype wire

/* sv/ifp_in_if.sv */
// Input channel of the converter: one infix character or an end marker per item.
`default_nettype none

interface ifp_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] symbol;

    modport source (output valid, output mode, output symbol, input ready);
    modport sink   (input valid, input mode, input symbol, output ready);
endinterface

`default_nettype wire

/* sv/ifp_out_if.sv */
// Output channel of the converter: one postfix character per item.
`default_nettype none

interface ifp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       last;
    logic       overflow;

    modport source (output valid, output out_symbol, output last, output overflow,
                    input ready);
    modport sink   (input valid, input out_symbol, input last, input overflow,
                    output ready);
endinterface

`default_nettype wire

/* sv/infix_to_postfix_converter_top.sv */
// Top level of the infix to postfix converter: operator stack in a memory and its sequencer.
//
//   channel   direction  payload                         handshake
//   i_in      in         mode, symbol                    valid / ready
//   o_out     out        out_symbol, last, overflow      valid / ready
//
// An item is accepted and then handled one sequencer step at a time: a letter, a push,
// an overflow report or an ignored ')' needs no pop, and each popped operator adds a
// step, since the stack memory gives one read per cycle and the new top arrives in the
// cycle after each pop. A flush pops every operator, then emits the last held one and
// the NUL end marker; on an empty stack it emits only the NUL end marker.
// Reset is synchronous and active low and empties the stack at once; the stack memory
// itself is not cleared. A stalled output holds the sequencer at its next result.
`default_nettype none

module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = ifp_pkg::STACK_DEPTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    ifp_in_if.sink           i_in,
    ifp_out_if.source        o_out
);
    import ifp_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {S_IDLE, S_WORK} t_state;
    typedef enum logic [2:0] {ACT_POP, ACT_FINAL, ACT_PUSH, ACT_DROP, ACT_NONE} t_act;

    // Stack memory and its registered read port
    logic [7:0]    r_mem [STACK_DEPTH];
    logic [7:0]    r_mem_q;

    t_state        r_state;
    logic          r_mode;
    logic [7:0]    r_sym;
    logic [CW-1:0] r_cnt;
    logic [7:0]    r_top;
    logic          r_top_sel;
    logic          r_hold_v;
    logic [7:0]    r_hold;
    logic          r_ov;
    logic [7:0]    r_osym;
    logic          r_olast;
    logic          r_oovf;

    t_act          act;
    logic [7:0]    fin_sym;
    logic          fin_ovf;
    logic [7:0]    top;
    logic          cnt_nz;
    logic          full;
    logic          out_free;
    logic          load_out;
    logic [7:0]    n_osym;
    logic          n_olast;
    logic          n_oovf;
    logic          do_pop;
    logic          do_push;
    logic          to_hold;
    logic          clr_hold;
    logic          done;
    logic [CW-1:0] cnt_m2;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign top      = r_top_sel ? r_mem_q : r_top;
    assign cnt_nz   = (r_cnt != '0);
    assign full     = (r_cnt == CW'(STACK_DEPTH));
    assign out_free = !r_ov || o_out.ready;
    assign cnt_m2   = r_cnt - CW'(2);
    assign rd_addr  = cnt_m2[AW-1:0];
    assign wr_addr  = r_cnt[AW-1:0];

    // Decide the next step for the current item from the stack top
    always_comb begin
        act     = ACT_NONE;
        fin_sym = r_sym;
        fin_ovf = 1'b0;
        if (r_mode == MODE_FLUSH) begin
            if (cnt_nz) begin
                act = ACT_POP;
            end else begin
                act     = ACT_FINAL;
                fin_sym = CH_NUL;
            end
        end else if (f_is_letter(r_sym)) begin
            act = ACT_FINAL;
        end else if (r_sym == CH_RPAR) begin
            if (cnt_nz) begin
                act = (top != CH_LPAR) ? ACT_POP : ACT_DROP;
            end
        end else if (r_sym != CH_LPAR && cnt_nz && f_rank(r_sym) <= f_rank(top)) begin
            act = ACT_POP;
        end else if (!full) begin
            act = ACT_PUSH;
        end else begin
            act     = ACT_FINAL;
            fin_ovf = 1'b1;
        end
    end

    // Turn the step into stack and output actions; a popped operator waits in the
    // hold register until the next step tells whether it is the last result
    always_comb begin
        load_out = 1'b0;
        n_osym   = r_hold;
        n_olast  = 1'b0;
        n_oovf   = 1'b0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        to_hold  = 1'b0;
        clr_hold = 1'b0;
        done     = 1'b0;
        if (r_state == S_WORK) begin
            if (r_hold_v) begin
                if (out_free) begin
                    load_out = 1'b1;
                    case (act)
                        ACT_POP: begin
                            do_pop  = 1'b1;
                            to_hold = 1'b1;
                        end
                        ACT_FINAL: begin
                            clr_hold = 1'b1;
                        end
                        ACT_PUSH: begin
                            n_olast  = 1'b1;
                            clr_hold = 1'b1;
                            do_push  = 1'b1;
                            done     = 1'b1;
                        end
                        ACT_DROP: begin
                            n_olast  = 1'b1;
                            clr_hold = 1'b1;
                            do_pop   = 1'b1;
                            done     = 1'b1;
                        end
                        default: begin
                            n_olast  = 1'b1;
                            clr_hold = 1'b1;
                            done     = 1'b1;
                        end
                    endcase
                end
            end else begin
                case (act)
                    ACT_POP: begin
                        do_pop  = 1'b1;
                        to_hold = 1'b1;
                    end
                    ACT_FINAL: begin
                        if (out_free) begin
                            load_out = 1'b1;
                            n_osym   = fin_sym;
                            n_olast  = 1'b1;
                            n_oovf   = fin_ovf;
                            done     = 1'b1;
                        end
                    end
                    ACT_PUSH: begin
                        do_push = 1'b1;
                        done    = 1'b1;
                    end
                    ACT_DROP: begin
                        do_pop = 1'b1;
                        done   = 1'b1;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.out_symbol = r_osym;
    assign o_out.last       = r_olast;
    assign o_out.overflow   = r_oovf;

    // Write a pushed operator; read the new top on a pop
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[wr_addr] <= r_sym;
        end
        if (do_pop) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // Sequencer state, stack count, top cache and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_mode  <= i_in.mode;
                        r_sym   <= i_in.symbol;
                        r_state <= S_WORK;
                    end
                end
                S_WORK: begin
                    if (done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (do_pop) begin
                r_cnt     <= r_cnt - CW'(1);
                r_top_sel <= 1'b1;
            end else if (do_push) begin
                r_cnt     <= r_cnt + CW'(1);
                r_top     <= r_sym;
                r_top_sel <= 1'b0;
            end

            if (to_hold) begin
                r_hold   <= top;
                r_hold_v <= 1'b1;
            end else if (clr_hold) begin
                r_hold_v <= 1'b0;
            end

            if (load_out) begin
                r_ov    <= 1'b1;
                r_osym  <= n_osym;
                r_olast <= n_olast;
                r_oovf  <= n_oovf;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/ifp_checker.sv */
// Port checker for the infix to postfix converter and its bind to the top level.
`default_nettype none

module ifp_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_out_last,
    input wire       i_out_overflow
);

    // Hold an offered output item until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped before it was taken");

    // Take no further item in the cycle after one is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted twice in a row");

    // End every item on an overflow report
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_overflow |-> i_out_last)
        else $error("overflow report not marked last");

    // Drop any offered output item on reset
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind infix_to_postfix_converter_top ifp_checker u_ifp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_last     (o_out.last),
    .i_out_overflow (o_out.overflow)
);

`default_nettype wire
